### hdl/dms_pkg.sv
// Shared types and constants for the middle snake search block.
`default_nettype none
package dms_pkg;
  localparam int unsigned TEXT_AW = 10;
  localparam int unsigned COORD_W = 11;
  localparam int unsigned SNAKE_W = 12;
  localparam int unsigned CHAR_W = 8;

  typedef enum logic [1:0] {
    FUNC_WR_FIRST  = 2'd0,
    FUNC_WR_SECOND = 2'd1,
    FUNC_SEARCH    = 2'd2,
    FUNC_NONE      = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]           func;
    logic [TEXT_AW-1:0]   char_index;
    logic [CHAR_W-1:0]    char_value;
    logic [COORD_W-1:0]   first_start;
    logic [COORD_W-1:0]   second_start;
    logic [COORD_W-1:0]   first_end;
    logic [COORD_W-1:0]   second_end;
  } req_t;

  typedef struct packed {
    logic signed [SNAKE_W-1:0] snake_first_begin;
    logic signed [SNAKE_W-1:0] snake_second_begin;
    logic signed [SNAKE_W-1:0] snake_first_finish;
    logic signed [SNAKE_W-1:0] snake_second_finish;
  } rsp_t;

  localparam logic signed [SNAKE_W-1:0] NO_COORD = -12'sd1;
endpackage
`default_nettype wire

### hdl/dms_if.sv
// Valid/ready channel carrying one payload.
`default_nettype none
interface dms_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/diff_middle_snake_search.sv
// Top level: text stores, frontier memories and the search sequencer.
`default_nettype none
// Middle snake search of the bidirectional Myers diff. Character writes (func 0 and 1)
// are accepted back to back. A search item (func 2) is run by one sequencer that
// walks the diagonals of both frontiers; each frontier step runs two frontier reads,
// start point, run test, store, overlap check and advance, and a run walks matched
// characters through registered text store reads until it stops on a mismatching
// character or the range end. The block is not ready while a search runs. The result
// goes to an output register; the next item is taken while it waits.
// Frontier memories need no clearing pass: a search reads only entries it wrote.
module diff_middle_snake_search #(
  parameter int unsigned MAX_TEXT_LEN   = 1024,
  parameter int unsigned FRONTIER_DEPTH = 4097
) (
  input  wire logic clk,
  input  wire logic rst,
  dms_if.sink   in_ch,
  dms_if.source out_ch
);
  import dms_pkg::*;

  localparam int unsigned TA = (MAX_TEXT_LEN > 1) ? $clog2(MAX_TEXT_LEN) : 1;
  localparam int unsigned FA = $clog2(FRONTIER_DEPTH);
  localparam int unsigned VW = COORD_W + 10; // room for signed diagonal math
  localparam int unsigned FW = COORD_W + 2;  // frontier entries run past both ends

  typedef logic signed [VW-1:0] val_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_KSTART, S_RD1, S_RD2, S_PICK, S_TXT, S_CMP, S_STORE,
    S_CHK, S_CHK2, S_NEXT, S_OUT
  } state_t;

  logic [CHAR_W-1:0] first_text [MAX_TEXT_LEN];
  logic [CHAR_W-1:0] second_text [MAX_TEXT_LEN];
  logic signed [FW-1:0] fwd_mem [FRONTIER_DEPTH];
  logic signed [FW-1:0] rev_mem [FRONTIER_DEPTH];

  state_t state;
  logic   dir; // 0 forward, 1 reverse
  val_t   ns, ms, ne, me, mx, dr, d, k, x, y, sx, sy, lo, hi;
  logic   odd;
  val_t   r0, r1, r2, r3;
  logic [CHAR_W-1:0] ca, cb;
  logic signed [FW-1:0] fa_q, rdq;
  val_t   ra, rb, ka;
  logic   out_valid;
  rsp_t   out_data;

  // frontier memory read, one shared port per array
  logic [FA-1:0] f_raddr;
  logic          f_rsel;
  val_t          f_ridx;
  logic          f_rok;

  function automatic val_t ext(input logic [COORD_W-1:0] v);
    ext = val_t'({1'b0, v});
  endfunction

  function automatic val_t clampv(input logic [COORD_W-1:0] v);
    clampv = (ext(v) > val_t'(MAX_TEXT_LEN)) ? val_t'(MAX_TEXT_LEN) : ext(v);
  endfunction

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  val_t ns_c, ms_c, ne_c, me_c;
  always_comb begin
    ns_c = clampv(in_ch.data.first_start);
    ms_c = clampv(in_ch.data.second_start);
    ne_c = clampv(in_ch.data.first_end);
    me_c = clampv(in_ch.data.second_end);
    if (ne_c < ns_c) ne_c = ns_c;
    if (me_c < ms_c) me_c = ms_c;
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      if (in_ch.data.func == FUNC_WR_FIRST && 32'(in_ch.data.char_index) < MAX_TEXT_LEN)
        first_text[TA'(in_ch.data.char_index)] <= in_ch.data.char_value;
      if (in_ch.data.func == FUNC_WR_SECOND && 32'(in_ch.data.char_index) < MAX_TEXT_LEN)
        second_text[TA'(in_ch.data.char_index)] <= in_ch.data.char_value;
    end
  end

  // text reads, registered; address chosen by direction
  val_t ta, tb;
  always_comb begin
    ta = dir ? x - val_t'(1) : x;
    tb = dir ? y - val_t'(1) : y;
  end
  always_ff @(posedge clk) begin
    ca <= (ta >= 0 && ta < val_t'(MAX_TEXT_LEN)) ? first_text[ta[TA-1:0]] : '0;
    cb <= (tb >= 0 && tb < val_t'(MAX_TEXT_LEN)) ? second_text[tb[TA-1:0]] : '0;
  end

  assign f_rok   = (f_ridx >= 0) && (f_ridx < val_t'(FRONTIER_DEPTH));
  assign f_raddr = f_ridx[FA-1:0];
  logic f_rok_q, f_rsel_q;
  always_ff @(posedge clk) begin
    fa_q     <= fwd_mem[f_raddr];
    rdq      <= rev_mem[f_raddr];
    f_rok_q  <= f_rok;
    f_rsel_q <= f_rsel;
  end
  val_t rd_val;
  assign rd_val = !f_rok_q ? '0 : (f_rsel_q ? val_t'(rdq) : val_t'(fa_q));

  logic fwr_en, rwr_en;
  assign fwr_en = (state == S_STORE) && !dir && ka >= 0 && ka < val_t'(FRONTIER_DEPTH);
  assign rwr_en = (state == S_STORE) && dir && ka >= 0 && ka < val_t'(FRONTIER_DEPTH);
  always_ff @(posedge clk) begin
    if (fwr_en) fwd_mem[ka[FA-1:0]] <= x[FW-1:0];
    if (rwr_en) rev_mem[ka[FA-1:0]] <= x[FW-1:0];
  end

  // read address mux
  always_comb begin
    f_rsel = dir;
    unique case (state)
      S_KSTART: f_ridx = ka + val_t'(1);
      S_RD1:    f_ridx = ka - val_t'(1);
      S_CHK: begin
        f_rsel = !dir;
        f_ridx = dir ? ka + dr : ka - dr;
      end
      default:  f_ridx = ka;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      dir       <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready && in_ch.data.func == FUNC_SEARCH) begin
            ns <= ns_c; ms <= ms_c; ne <= ne_c; me <= me_c;
            mx <= (ne_c - ns_c) + (me_c - ms_c);
            dr <= (ne_c - ns_c) - (me_c - ms_c);
            state <= S_INIT;
          end
        end
        S_INIT: begin
          odd <= dr[0];
          r0 <= val_t'(NO_COORD); r1 <= val_t'(NO_COORD);
          r2 <= val_t'(NO_COORD); r3 <= val_t'(NO_COORD);
          d <= '0; k <= '0; ka <= mx; dir <= 1'b0;
          state <= S_KSTART;
        end
        S_KSTART: state <= S_RD1;
        S_RD1: begin
          rb <= rd_val; // entry ka+1
          state <= S_RD2;
        end
        S_RD2: begin
          ra <= rd_val; // entry ka-1
          state <= S_PICK;
        end
        S_PICK: begin
          // choose start point on this diagonal
          val_t xv;
          xv = '0;
          if (!dir) begin
            if (d == 0) xv = ns;
            else if (k == -d) xv = rb;
            else if (k == d) xv = ra + val_t'(1);
            else if (ra < rb) xv = rb;
            else xv = ra + val_t'(1);
            x <= xv; sx <= xv;
            y <= ms + (xv - ns) - k;
            sy <= ms + (xv - ns) - k;
          end else begin
            if (d == 0) xv = ne;
            else if (k == -d) xv = rb - val_t'(1);
            else if (k == d) xv = ra;
            else if (rb < ra) xv = rb - val_t'(1);
            else xv = ra;
            x <= xv; sx <= xv;
            y <= ms + (xv - ns) - k - dr;
            sy <= ms + (xv - ns) - k - dr;
          end
          state <= S_TXT;
        end
        S_TXT: begin
          if (!dir ? (x < ne && y < me) : (x > ns && y > ms)) state <= S_CMP;
          else state <= S_STORE;
        end
        S_CMP: begin
          if (ca == cb) begin
            if (!dir) begin
              x <= x + val_t'(1); y <= y + val_t'(1);
              r0 <= sx; r1 <= sy; r2 <= x + val_t'(1); r3 <= y + val_t'(1);
            end else begin
              x <= x - val_t'(1); y <= y - val_t'(1);
              r0 <= x - val_t'(1); r1 <= y - val_t'(1); r2 <= sx; r3 <= sy;
            end
            state <= S_TXT;
          end else state <= S_STORE;
        end
        S_STORE: begin
          if (!dir) begin
            lo <= -d + val_t'(1); hi <= d - val_t'(1);
          end else begin
            lo <= -d; hi <= d;
          end
          state <= S_CHK;
        end
        S_CHK: state <= S_CHK2;
        S_CHK2: begin
          logic stop;
          stop = 1'b0;
          if (!dir) begin
            if (odd && (k - dr) >= lo && (k - dr) <= hi && rd_val <= x) stop = 1'b1;
            if (x == ne && y == me) stop = 1'b1;
          end else begin
            if (!odd && (k + dr) >= lo && (k + dr) <= hi && rd_val >= x) stop = 1'b1;
            if (x == ns && y == ms) stop = 1'b1;
          end
          state <= stop ? S_OUT : S_NEXT;
        end
        S_NEXT: begin
          if (k + val_t'(2) <= d) begin
            k <= k + val_t'(2); ka <= ka + val_t'(2);
            state <= S_KSTART;
          end else if (!dir) begin
            dir <= 1'b1; k <= -d; ka <= mx - d;
            state <= S_KSTART;
          end else if (d + val_t'(1) <= mx) begin
            dir <= 1'b0; d <= d + val_t'(1);
            k <= -(d + val_t'(1)); ka <= mx - d - val_t'(1);
            state <= S_KSTART;
          end else state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_data.snake_first_begin   <= r0[SNAKE_W-1:0];
            out_data.snake_second_begin  <= r1[SNAKE_W-1:0];
            out_data.snake_first_finish  <= r2[SNAKE_W-1:0];
            out_data.snake_second_finish <= r3[SNAKE_W-1:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("ready while searching");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> $stable(out_data)) else $error("result changed");
  a_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT) else $error("result from nowhere");
`endif
endmodule
`default_nettype wire

### tb/sv/diff_middle_snake_search_tb.sv
// Self-checking testbench for the middle snake search block.
`default_nettype none
module diff_middle_snake_search_tb;
  import dms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_LEN = 1024;
  localparam int FR_DEPTH = 4097;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  dms_if #(.T(req_t)) req_ch ();
  dms_if #(.T(rsp_t)) rsp_ch ();

  diff_middle_snake_search u_top (
    .clk(clk), .rst(rst), .in_ch(req_ch.sink), .out_ch(rsp_ch.source)
  );

  logic [CHAR_W-1:0] first_chars [TEXT_LEN];
  logic [CHAR_W-1:0] second_chars [TEXT_LEN];
  bit first_known [TEXT_LEN];
  bit second_known [TEXT_LEN];
  int fwd_x [FR_DEPTH];
  int rev_u [FR_DEPTH];

  req_t pending_reqs[$];
  rsp_t snake_queue[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit hold_sender = 1'b0;

  function automatic int fwd_rd(int i);
    return (i < 0 || i >= FR_DEPTH) ? 0 : fwd_x[i];
  endfunction

  function automatic int rev_rd(int i);
    return (i < 0 || i >= FR_DEPTH) ? 0 : rev_u[i];
  endfunction

  function automatic void fwd_wr(int i, int v);
    if (i >= 0 && i < FR_DEPTH) fwd_x[i] = v;
  endfunction

  function automatic void rev_wr(int i, int v);
    if (i >= 0 && i < FR_DEPTH) rev_u[i] = v;
  endfunction

  function automatic int clamp_coord(logic [COORD_W-1:0] v);
    return (v > TEXT_LEN) ? TEXT_LEN : int'(v);
  endfunction

  // Bidirectional greedy search; r holds the last walked run.
  function automatic rsp_t find_middle_snake(int ns, int ms, int ne, int me);
    int mx, dr, d, k, ka, x, y, sx, sy, u, v, su, sv;
    int r[4];
    bit odd;
    rsp_t res;
    mx = (ne - ns) + (me - ms);
    dr = (ne - ns) - (me - ms);
    odd = dr[0];
    r = '{-1, -1, -1, -1};
    for (d = 0; d <= mx; d++) begin
      for (k = -d; k <= d; k += 2) begin
        ka = k + mx;
        if (d == 0) x = ns;
        else if (k == -d) x = fwd_rd(ka + 1);
        else if (k == d) x = fwd_rd(ka - 1) + 1;
        else if (fwd_rd(ka - 1) < fwd_rd(ka + 1)) x = fwd_rd(ka + 1);
        else x = fwd_rd(ka - 1) + 1;
        y = ms + (x - ns) - k;
        sx = x; sy = y;
        while (x < ne && y < me && first_chars[x] == second_chars[y]) begin
          x++; y++;
          r = '{sx, sy, x, y};
        end
        fwd_wr(ka, x);
        if (odd && k - dr >= -d + 1 && k - dr <= d - 1 && rev_rd(ka - dr) <= x) begin
          d = mx + 1;
          break;
        end
        if (x == ne && y == me) begin
          d = mx + 1;
          break;
        end
      end
      if (d > mx) break;
      for (k = -d; k <= d; k += 2) begin
        ka = k + mx;
        if (d == 0) u = ne;
        else if (k == -d) u = rev_rd(ka + 1) - 1;
        else if (k == d) u = rev_rd(ka - 1);
        else if (rev_rd(ka + 1) < rev_rd(ka - 1)) u = rev_rd(ka + 1) - 1;
        else u = rev_rd(ka - 1);
        v = ms + (u - ns) - k - dr;
        su = u; sv = v;
        while (u > ns && v > ms && first_chars[u-1] == second_chars[v-1]) begin
          u--; v--;
          r = '{u, v, su, sv};
        end
        rev_wr(ka, u);
        if (!odd && k + dr >= -d && k + dr <= d && fwd_rd(ka + dr) >= u) begin
          d = mx + 1;
          break;
        end
        if (u == ns && v == ms) begin
          d = mx + 1;
          break;
        end
      end
    end
    res.snake_first_begin = r[0][SNAKE_W-1:0];
    res.snake_second_begin = r[1][SNAKE_W-1:0];
    res.snake_first_finish = r[2][SNAKE_W-1:0];
    res.snake_second_finish = r[3][SNAKE_W-1:0];
    return res;
  endfunction

  // Update the text copy and queue the expected snake for one accepted item.
  function automatic void predict(req_t q);
    int ns, ms, ne, me;
    case (func_t'(q.func))
      FUNC_WR_FIRST: first_chars[q.char_index] = q.char_value;
      FUNC_WR_SECOND: second_chars[q.char_index] = q.char_value;
      FUNC_SEARCH: begin
        ns = clamp_coord(q.first_start);
        ms = clamp_coord(q.second_start);
        ne = clamp_coord(q.first_end);
        me = clamp_coord(q.second_end);
        if (ne < ns) ne = ns;
        if (me < ms) me = ms;
        snake_queue.push_back(find_middle_snake(ns, ms, ne, me));
      end
      default: ;
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t q;
    q.func = 2'($urandom_range(0, 3));
    q.char_index = 10'($urandom);
    q.char_value = 8'($urandom);
    q.first_start = 11'($urandom);
    q.second_start = 11'($urandom);
    q.first_end = 11'($urandom);
    q.second_end = 11'($urandom);
    return q;
  endfunction

  function automatic req_t char_req(func_t f, int idx, int ch);
    req_t q;
    q = rand_req();
    q.func = f;
    q.char_index = idx[TEXT_AW-1:0];
    q.char_value = ch[CHAR_W-1:0];
    first_known[idx] |= (f == FUNC_WR_FIRST);
    second_known[idx] |= (f == FUNC_WR_SECOND);
    return q;
  endfunction

  // Only ranges over written characters may be searched; raw bounds may exceed the store.
  function automatic req_t search_req(int ns, int ms, int ne, int me);
    req_t q;
    q = rand_req();
    q.func = FUNC_SEARCH;
    q.first_start = ns[COORD_W-1:0];
    q.second_start = ms[COORD_W-1:0];
    q.first_end = ne[COORD_W-1:0];
    q.second_end = me[COORD_W-1:0];
    return q;
  endfunction

  function automatic bit range_known(int ns, int ne, bit first);
    int s, e;
    s = (ns > TEXT_LEN) ? TEXT_LEN : ns;
    e = (ne > TEXT_LEN) ? TEXT_LEN : ne;
    for (int i = s; i < e; i++)
      if (!(first ? first_known[i] : second_known[i])) return 1'b0;
    return 1'b1;
  endfunction

  // Write a short pair of random strings at random bases, then search over them.
  task automatic add_pair(int len_a, int len_b, int alpha);
    int base_a, base_b, ch;
    base_a = $urandom_range(0, TEXT_LEN - len_a);
    base_b = $urandom_range(0, TEXT_LEN - len_b);
    for (int i = 0; i < len_a; i++)
      pending_reqs.push_back(char_req(FUNC_WR_FIRST, base_a + i, $urandom_range(0, alpha)));
    for (int i = 0; i < len_b; i++) begin
      ch = $urandom_range(0, alpha);
      pending_reqs.push_back(char_req(FUNC_WR_SECOND, base_b + i, ch));
    end
    pending_reqs.push_back(search_req(base_a, base_b, base_a + len_a, base_b + len_b));
  endtask

  // Sender: bursts and gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_sender) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_reqs.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) if (!rst && req_ch.valid && req_ch.ready) predict(req_ch.data);

  // Receiver: stall pattern alternating between busy and free stretches.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9]) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  rsp_t want;
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (snake_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected snake result %p", rsp_ch.data);
      end else begin
        want = snake_queue.pop_front();
        if (rsp_ch.data !== want) begin
          errors++;
          if (errors <= 10)
            $display("snake mismatch: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
              want.snake_first_begin, want.snake_second_begin,
              want.snake_first_finish, want.snake_second_finish,
              rsp_ch.data.snake_first_begin, rsp_ch.data.snake_second_begin,
              rsp_ch.data.snake_first_finish, rsp_ch.data.snake_second_finish);
        end
      end
    end
  end

  initial begin
    int ns, ne, ms, me;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    foreach (first_chars[i]) begin
      first_chars[i] = '0;
      second_chars[i] = '0;
      first_known[i] = 1'b0;
      second_known[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: store extremes, ignored code, empty/inverted/saturated ranges.
    pending_reqs.push_back(char_req(FUNC_WR_FIRST, 0, 8'hff));
    pending_reqs.push_back(char_req(FUNC_WR_SECOND, 0, 8'hff));
    pending_reqs.push_back(char_req(FUNC_WR_FIRST, 1023, 8'h00));
    pending_reqs.push_back(char_req(FUNC_WR_SECOND, 1023, 8'h00));
    pending_reqs.push_back(char_req(FUNC_WR_FIRST, 1, 8'h55));
    pending_reqs.push_back(char_req(FUNC_WR_SECOND, 1, 8'haa));
    begin
      req_t q;
      q = rand_req();
      q.func = FUNC_NONE;
      pending_reqs.push_back(q);
    end
    pending_reqs.push_back(search_req(0, 0, 0, 0));
    pending_reqs.push_back(search_req(5, 7, 2, 3));
    pending_reqs.push_back(search_req(2047, 2047, 0, 1500));
    pending_reqs.push_back(search_req(1023, 1023, 2047, 2047));
    pending_reqs.push_back(search_req(0, 0, 2, 2));
    pending_reqs.push_back(search_req(0, 0, 1, 2));
    pending_reqs.push_back(search_req(0, 1, 2, 2));
    pending_reqs.push_back(search_req(0, 0, 2, 0));
    add_pair(4, 4, 1);
    add_pair(5, 2, 2);

    // Pause until all results are in.
    wait (pending_reqs.size() == 0 && !req_ch.valid);
    hold_sender = 1'b1;
    wait (snake_queue.size() == 0);
    repeat (20) @(posedge clk);
    hold_sender = 1'b0;

    for (int n = 0; n < 52; n++) begin
      case ($urandom_range(0, 9))
        0: begin
          // Noise: stray writes, ignored code, searches over written areas only.
          for (int i = 0; i < 3; i++) begin
            req_t q;
            q = rand_req();
            if (q.func == FUNC_SEARCH) begin
              ns = q.first_start; ne = q.first_end;
              ms = q.second_start; me = q.second_end;
              if (!range_known(ns, ne, 1) || !range_known(ms, me, 0)) q.func = FUNC_NONE;
            end else if (q.func == FUNC_WR_FIRST) begin
              first_known[q.char_index] = 1'b1;
            end else if (q.func == FUNC_WR_SECOND) begin
              second_known[q.char_index] = 1'b1;
            end
            pending_reqs.push_back(q);
          end
        end
        1: add_pair($urandom_range(0, 3), $urandom_range(0, 3), 255);
        2: add_pair($urandom_range(20, 40), $urandom_range(20, 40), 1);
        default: add_pair($urandom_range(1, 14), $urandom_range(1, 14),
                          $urandom_range(1, 3));
      endcase
    end
    stim_done = 1'b1;
    wait (pending_reqs.size() == 0 && !req_ch.valid);
    wait (snake_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && snake_queue.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
